/* rtl/fud_pkg.sv */
// package: types, character codes and decode helpers for the form body decoder
package fud_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // hex digit value, bit 4 set when the byte is no hex digit
  localparam logic [4:0] NO_HEX = 5'd16;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_NAME  = 3'd1,
    PH_VALUE = 3'd2,
    PH_PCT1  = 3'd3,
    PH_PCT2  = 3'd4,
    PH_DONE  = 3'd5
  } fud_phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       body_last;
  } fud_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       role;
    logic       pair_end;
    logic       body_end;
    logic       status;
  } fud_res_t;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = NO_HEX;
    if (c inside {[8'h30:8'h39]}) begin
      v = 5'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      v = 5'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      v = 5'(c - 8'h37);
    end
    return v;
  endfunction

  function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] ha;
    logic [4:0] hb;
    logic [7:0] r;
    ha = hex_val(a);
    hb = hex_val(b);
    if (ha[4]) begin
      r = 8'h00;
    end else if (hb[4]) begin
      r = {4'h0, ha[3:0]};
    end else begin
      r = {ha[3:0], hb[3:0]};
    end
    return r;
  endfunction

  function automatic logic [7:0] plain(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

  function automatic fud_res_t make_res(input logic [7:0] b, input logic has,
                                        input logic role, input logic pe,
                                        input logic be, input logic st);
    fud_res_t r;
    r.out_byte = has ? b : 8'h00;
    r.has_byte = has;
    r.role     = role;
    r.pair_end = pe;
    r.body_end = be;
    r.status   = st;
    return r;
  endfunction

endpackage

/* rtl/fud_ifs.sv */
// interfaces: body byte channel and decoded word channel
interface fud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       body_last;

  modport source (output valid, output in_byte, output body_last, input ready);
  modport sink (input valid, input in_byte, input body_last, output ready);
endinterface

interface fud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       role;
  logic       pair_end;
  logic       body_end;
  logic       status;

  modport source (output valid, output out_byte, output has_byte, output role,
                  output pair_end, output body_end, output status, input ready);
  modport sink (input valid, input out_byte, input has_byte, input role,
                input pair_end, input body_end, input status, output ready);
endinterface

/* rtl/fud_parser.sv */
// parser: phase machine and value decode for one body byte
module fud_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_i,
  input  fud_pkg::fud_item_t  item_i,
  output logic                emit_o,
  output fud_pkg::fud_res_t   res_o
);

  fud_pkg::fud_phase_t phase_r, phase_nxt;
  logic [7:0]          held_r, held_nxt;

  logic [7:0] b;
  logic       last;
  logic       is_nul;
  logic       is_term;

  assign b       = item_i.in_byte;
  assign last    = item_i.body_last;
  assign is_nul  = (b == fud_pkg::CH_NUL);
  assign is_term = is_nul || (b == fud_pkg::CH_AMP);

  // result for the current byte
  always_comb begin
    emit_o = 1'b0;
    res_o  = '0;
    case (phase_r)
      fud_pkg::PH_START, fud_pkg::PH_NAME: begin
        if (is_nul) begin
          if (phase_r == fud_pkg::PH_NAME) begin
            emit_o = 1'b1;
            res_o  = fud_pkg::make_res(8'h00, 1'b0, 1'b0, 1'b1, last, 1'b1);
          end else if (last) begin
            emit_o = 1'b1;
            res_o  = fud_pkg::make_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
          end
        end else if (b == fud_pkg::CH_EQ) begin
          if (last) begin
            emit_o = 1'b1;
            res_o  = fud_pkg::make_res(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
          end
        end else begin
          emit_o = 1'b1;
          res_o  = fud_pkg::make_res(b, 1'b1, 1'b0, last, last, last);
        end
      end
      fud_pkg::PH_VALUE: begin
        if (is_term) begin
          emit_o = 1'b1;
          res_o  = fud_pkg::make_res(8'h00, 1'b0, 1'b1, 1'b1, last, 1'b0);
        end else if (b == fud_pkg::CH_PCT) begin
          if (last) begin
            emit_o = 1'b1;
            res_o  = fud_pkg::make_res(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
          end
        end else begin
          emit_o = 1'b1;
          res_o  = fud_pkg::make_res(fud_pkg::plain(b), 1'b1, 1'b1, last, last, 1'b0);
        end
      end
      fud_pkg::PH_PCT1: begin
        if (is_term) begin
          emit_o = 1'b1;
          res_o  = fud_pkg::make_res(8'h00, 1'b0, 1'b1, 1'b1, last, 1'b0);
        end else if (b == fud_pkg::CH_PCT) begin
          emit_o = 1'b1;
          res_o  = fud_pkg::make_res(fud_pkg::CH_PCT, 1'b1, 1'b1, last, last, 1'b0);
        end else if (last) begin
          emit_o = 1'b1;
          res_o  = fud_pkg::make_res(fud_pkg::plain(b), 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        end
      end
      fud_pkg::PH_PCT2: begin
        emit_o = 1'b1;
        if (is_term) begin
          // short escape, the held byte goes out as a plain value byte
          res_o = fud_pkg::make_res(fud_pkg::plain(held_r), 1'b1, 1'b1, 1'b1, last, 1'b0);
        end else begin
          res_o = fud_pkg::make_res(fud_pkg::decode_pair(held_r, b), 1'b1, 1'b1,
                                    last, last, 1'b0);
        end
      end
      default: begin
        if (last) begin
          emit_o = 1'b1;
          res_o  = fud_pkg::make_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        end
      end
    endcase
  end

  // next phase and held escape byte
  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    case (phase_r)
      fud_pkg::PH_START, fud_pkg::PH_NAME: begin
        if (is_nul) begin
          phase_nxt = fud_pkg::PH_DONE;
        end else if (b == fud_pkg::CH_EQ) begin
          phase_nxt = fud_pkg::PH_VALUE;
        end else begin
          phase_nxt = fud_pkg::PH_NAME;
        end
      end
      fud_pkg::PH_VALUE: begin
        if (is_term) begin
          phase_nxt = is_nul ? fud_pkg::PH_DONE : fud_pkg::PH_START;
        end else if (b == fud_pkg::CH_PCT) begin
          phase_nxt = fud_pkg::PH_PCT1;
        end
      end
      fud_pkg::PH_PCT1: begin
        if (is_term) begin
          phase_nxt = is_nul ? fud_pkg::PH_DONE : fud_pkg::PH_START;
        end else if (b == fud_pkg::CH_PCT) begin
          phase_nxt = fud_pkg::PH_VALUE;
        end else if (!last) begin
          held_nxt  = b;
          phase_nxt = fud_pkg::PH_PCT2;
        end
      end
      fud_pkg::PH_PCT2: begin
        if (is_term) begin
          phase_nxt = is_nul ? fud_pkg::PH_DONE : fud_pkg::PH_START;
        end else begin
          phase_nxt = fud_pkg::PH_VALUE;
        end
      end
      default: begin
        phase_nxt = fud_pkg::PH_DONE;
      end
    endcase
    if (last) begin
      phase_nxt = fud_pkg::PH_START;
      held_nxt  = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fud_pkg::PH_START;
      held_r  <= 8'h00;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && item_i.body_last |-> emit_o && res_o.body_end)
    else $error("last body byte gave no body end word");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && item_i.body_last |=> phase_r == fud_pkg::PH_START && held_r == 8'h00)
    else $error("phase not back at name start after body end");

  a_status_ends_pair: assert property (@(posedge clk) disable iff (!rst_n)
    emit_o && res_o.status |-> res_o.pair_end && !res_o.role)
    else $error("discard status without name pair end");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    emit_o && !res_o.has_byte |-> res_o.out_byte == 8'h00)
    else $error("marker word carries a byte");

endmodule

/* rtl/form_urlencoded_decoder.sv */
// top level: form body decoder with input register and result register
//
//   channel | dir | words                         | accepted when
//   in_ch   | in  | in_byte, body_last            | valid && ready
//   out_ch  | out | out_byte, has_byte, role,     | valid && ready
//           |     | pair_end, body_end, status    |
//
// one byte per cycle sustained while the result register is not stalled; an accepted
// byte waits in the input register and its word (if any) is loaded into the result
// register in the cycle after the byte moves on
// rst_n (synchronous, active low) clears both valid flags and the phase machine
// a stalled output holds only bytes that give a word; bytes that give none
// pass through the parser even while the result register waits
module form_urlencoded_decoder (
  input  logic          clk,
  input  logic          rst_n,
  fud_in_if.sink        in_ch,
  fud_out_if.source     out_ch
);

  // input register
  logic               in_v_r;
  fud_pkg::fud_item_t in_item_r;

  // result register
  logic               out_v_r;
  fud_pkg::fud_res_t  out_res_r;

  logic              emit;
  fud_pkg::fud_res_t res;
  logic              advance;

  // the byte in the input register moves on when its word, if any, has room
  assign advance     = in_v_r && (!emit || !out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.in_byte   <= in_ch.in_byte;
      in_item_r.body_last <= in_ch.body_last;
    end
  end

  fud_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (advance),
    .item_i (in_item_r),
    .emit_o (emit),
    .res_o  (res)
  );

  // result register loads a new word or drains when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && emit) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.out_byte = out_res_r.out_byte;
  assign out_ch.has_byte = out_res_r.has_byte;
  assign out_ch.role     = out_res_r.role;
  assign out_ch.pair_end = out_res_r.pair_end;
  assign out_ch.body_end = out_res_r.body_end;
  assign out_ch.status   = out_res_r.status;

  a_word_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance && emit |=> out_v_r)
    else $error("parsed word did not reach the result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready && in_v_r && emit |-> !advance)
    else $error("pending word would be overwritten");

  a_in_drains: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && (!out_v_r || out_ch.ready) |-> advance && in_ch.ready)
    else $error("input register stalled with free result register");

endmodule

/* tb/tb_form_urlencoded_decoder.sv */
// testbench: form body decoder checked word by word against its own predictor
module tb_form_urlencoded_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  // run shape
  localparam int ITEMS_TARGET = 1150;  // accepted body bytes before the random part stops
  localparam int STALL_LIMIT  = 1000;  // cycles with no word moving on either side
  localparam int RX_HOLD_LEN  = 80;    // long receiver hold-off, fills the block
  localparam int DRAIN_TAIL   = 6;     // idle cycles after the last expected word has come
  localparam int MAX_REPORTS  = 10;

  // characters the predictor needs beyond the package set
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;

  // character sets for building bodies
  localparam string HEX_CHARS  = "0123456789abcdefABCDEF";
  localparam string NAME_CHARS = "abcdefghijklmnopqrstuvwxyz0123456789_-.";
  localparam string TEXT_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789*~!.";
  localparam string NON_HEX    = "ghxyzGXZ+-_~";

  typedef enum int {
    RX_STEADY,   // always ready
    RX_COIN,     // ready on a coin flip
    RX_SPARSE,   // occasional random stalls
    RX_PATTERN   // fixed duty cycle over a short period
  } rx_mode_t;

  // ---------------------------------------------------------------------------
  // scoreboard: tracks the parse phase of the body and queues the word that
  // each accepted byte should produce, if any, then checks words in arrival order
  // ---------------------------------------------------------------------------
  class form_body_scoreboard;
    fud_pkg::fud_phase_t ph;
    logic [7:0]          held;
    fud_pkg::fud_res_t   pending_words[$];
    int                  mismatches;

    function new();
      ph         = fud_pkg::PH_START;
      held       = 8'h00;
      mismatches = 0;
    endfunction

    function void queue_word(logic [7:0] d, logic has, logic role, logic pe,
                             logic be, logic st);
      fud_pkg::fud_res_t w;
      w.out_byte = has ? d : 8'h00;
      w.has_byte = has;
      w.role     = role;
      w.pair_end = pe;
      w.body_end = be;
      w.status   = st;
      pending_words.push_back(w);
    endfunction

    function logic [4:0] hex_nibble(logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return {1'b0, 4'(c - CH_0)};
      if (c >= CH_LA && c <= CH_LF) return {1'b0, 4'(c - CH_LA + 8'd10)};
      if (c >= CH_UA && c <= CH_UF) return {1'b0, 4'(c - CH_UA + 8'd10)};
      return 5'h10;
    endfunction

    function logic [7:0] plus_to_space(logic [7:0] c);
      return (c == fud_pkg::CH_PLUS) ? fud_pkg::CH_SPACE : c;
    endfunction

    function void take_body_byte(fud_pkg::fud_item_t it);
      logic [7:0] b;
      logic       last;
      logic [4:0] hi;
      logic [4:0] lo;
      logic [7:0] d;
      b    = it.in_byte;
      last = it.body_last;
      case (ph)
        fud_pkg::PH_START, fud_pkg::PH_NAME: begin
          if (b == fud_pkg::CH_NUL) begin
            // a started name is dropped, an empty one leaves no pair behind
            if (ph == fud_pkg::PH_NAME) queue_word(8'h00, 1'b0, 1'b0, 1'b1, last, 1'b1);
            else if (last) queue_word(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
            ph = fud_pkg::PH_DONE;
          end else if (b == fud_pkg::CH_EQ) begin
            if (last) queue_word(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
            ph = fud_pkg::PH_VALUE;
          end else begin
            // name bytes go out at once; a last one flags the discarded name
            queue_word(b, 1'b1, 1'b0, last, last, last);
            ph = fud_pkg::PH_NAME;
          end
        end
        fud_pkg::PH_VALUE: begin
          if (b == fud_pkg::CH_NUL || b == fud_pkg::CH_AMP) begin
            queue_word(8'h00, 1'b0, 1'b1, 1'b1, last, 1'b0);
            ph = (b == fud_pkg::CH_NUL) ? fud_pkg::PH_DONE : fud_pkg::PH_START;
          end else if (b == fud_pkg::CH_PCT) begin
            if (last) queue_word(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
            ph = fud_pkg::PH_PCT1;
          end else begin
            queue_word(plus_to_space(b), 1'b1, 1'b1, last, last, 1'b0);
          end
        end
        fud_pkg::PH_PCT1: begin
          if (b == fud_pkg::CH_NUL || b == fud_pkg::CH_AMP) begin
            queue_word(8'h00, 1'b0, 1'b1, 1'b1, last, 1'b0);
            ph = (b == fud_pkg::CH_NUL) ? fud_pkg::PH_DONE : fud_pkg::PH_START;
          end else if (b == fud_pkg::CH_PCT) begin
            queue_word(fud_pkg::CH_PCT, 1'b1, 1'b1, last, last, 1'b0);
            ph = fud_pkg::PH_VALUE;
          end else if (last) begin
            // short escape, the lone byte stays a plain value byte
            queue_word(plus_to_space(b), 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
          end else begin
            held = b;
            ph   = fud_pkg::PH_PCT2;
          end
        end
        fud_pkg::PH_PCT2: begin
          if (b == fud_pkg::CH_NUL || b == fud_pkg::CH_AMP) begin
            queue_word(plus_to_space(held), 1'b1, 1'b1, 1'b1, last, 1'b0);
            ph = (b == fud_pkg::CH_NUL) ? fud_pkg::PH_DONE : fud_pkg::PH_START;
          end else begin
            hi = hex_nibble(held);
            lo = hex_nibble(b);
            if (hi[4]) d = 8'h00;
            else if (lo[4]) d = {4'h0, hi[3:0]};
            else d = {hi[3:0], lo[3:0]};
            queue_word(d, 1'b1, 1'b1, last, last, 1'b0);
            ph = fud_pkg::PH_VALUE;
          end
        end
        default: begin
          if (last) queue_word(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
          ph = fud_pkg::PH_DONE;
        end
      endcase
      if (last) begin
        ph   = fud_pkg::PH_START;
        held = 8'h00;
      end
    endfunction

    function string show(fud_pkg::fud_res_t w);
      return $sformatf("byte=%02h has=%0b role=%0b pair_end=%0b body_end=%0b status=%0b",
                       w.out_byte, w.has_byte, w.role, w.pair_end, w.body_end, w.status);
    endfunction

    function void check_word(fud_pkg::fud_res_t got);
      fud_pkg::fud_res_t want;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected word: %s", show(got));
        return;
      end
      want = pending_words.pop_front();
      if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
          got.role !== want.role || got.pair_end !== want.pair_end ||
          got.body_end !== want.body_end || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("word mismatch: expected %s, got %s", show(want), show(got));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fud_in_if  in_ch ();
  fud_out_if out_ch ();

  form_urlencoded_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  form_body_scoreboard sb = new();

  logic [7:0] body_q[$];   // bytes of the body being built
  int         bytes_sent;   // accepted body bytes
  int         burst_left;
  bit         gaps_on;
  bit         hold_req;     // main asks the receiver for a long hold-off

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // monitor: every edge with valid && ready moves one word; inputs are all
  // driven by nonblocking assignments, so these reads see pre-edge values
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    fud_pkg::fud_item_t it;
    fud_pkg::fud_res_t  got;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      it.in_byte   = in_ch.in_byte;
      it.body_last = in_ch.body_last;
      sb.take_body_byte(it);
      bytes_sent++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.out_byte = out_ch.out_byte;
      got.has_byte = out_ch.has_byte;
      got.role     = out_ch.role;
      got.pair_end = out_ch.pair_end;
      got.body_end = out_ch.body_end;
      got.status   = out_ch.status;
      sb.check_word(got);
    end
  end

  // watchdog: ends the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
        quiet = 0;
      else if (rst_n)
        quiet++;
    end
    $display("form_urlencoded_decoder regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: switches between stall patterns at random intervals; a hold
  // request from the main thread overrides the pattern with a long stretch of
  // ready low, counted here
  // ---------------------------------------------------------------------------
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_cnt;
    int       period;
    int       duty;
    int       tick;
    out_ch.ready <= 1'b0;
    mode      = RX_STEADY;
    mode_left = 0;
    hold_cnt  = 0;
    period    = 2;
    duty      = 1;
    tick      = 0;
    forever begin
      @(posedge clk);
      if (hold_cnt == 0 && hold_req) begin
        hold_cnt = RX_HOLD_LEN;
        hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 200);
        period    = $urandom_range(2, 8);
        duty      = $urandom_range(1, period - 1);
      end
      mode_left--;
      tick++;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_STEADY:  out_ch.ready <= 1'b1;
          RX_COIN:    out_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE:  out_ch.ready <= ($urandom_range(0, 7) != 0);
          default:    out_ch.ready <= ((tick % period) < duty);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender: offers one body byte and waits for it to be taken; bursts of random
  // length with random gaps between them while gaps are enabled, back to back
  // otherwise; valid stays high across a burst
  // ---------------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.body_last <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // sends the built body, flagging its final byte, and clears it
  task automatic send_body();
    for (int i = 0; i < body_q.size(); i++) put_byte(body_q[i], i == body_q.size() - 1);
    body_q.delete();
  endtask

  // sender pauses until every expected word has come, then waits out the drain tail
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_from(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // one value token: plain text, plus, escaped percent, full or partial escapes, or a random byte
  function automatic void push_value_token();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: body_q.push_back(pick_from(TEXT_CHARS));
      4: body_q.push_back(fud_pkg::CH_PLUS);
      5: push_text("%%");
      6: begin
        body_q.push_back(fud_pkg::CH_PCT);
        body_q.push_back(pick_from(HEX_CHARS));
        body_q.push_back(pick_from(HEX_CHARS));
      end
      7: begin
        // one leading hex digit only
        body_q.push_back(fud_pkg::CH_PCT);
        body_q.push_back(pick_from(HEX_CHARS));
        body_q.push_back(pick_from(NON_HEX));
      end
      8: begin
        body_q.push_back(fud_pkg::CH_PCT);
        body_q.push_back(pick_from(NON_HEX));
        body_q.push_back(8'($urandom_range(1, 255)));
      end
      default: body_q.push_back(8'($urandom_range(1, 255)));
    endcase
  endfunction

  // mostly well-formed bodies with random content; some get a zero byte
  // somewhere, some are pure noise
  function automatic void build_body();
    int kind;
    int npairs;
    int pos;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 12)) body_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    npairs = $urandom_range(1, 3);
    for (int p = 0; p < npairs; p++) begin
      if (p > 0) body_q.push_back(fud_pkg::CH_AMP);
      repeat ($urandom_range(0, 4)) body_q.push_back(pick_from(NAME_CHARS));
      // odd bytes inside a name, '&' among them
      if ($urandom_range(0, 9) == 0) body_q.push_back(8'($urandom_range(1, 255)));
      body_q.push_back(fud_pkg::CH_EQ);
      repeat ($urandom_range(0, 5)) push_value_token();
    end
    case ($urandom_range(0, 7))
      0: body_q.push_back(fud_pkg::CH_AMP);
      1: repeat ($urandom_range(1, 3)) body_q.push_back(pick_from(NAME_CHARS));
      2: body_q.push_back(fud_pkg::CH_PCT);
      3: begin
        body_q.push_back(fud_pkg::CH_PCT);
        body_q.push_back(pick_from(HEX_CHARS));
      end
      default: ;
    endcase
    if (kind >= 7) begin
      pos = $urandom_range(0, body_q.size());
      if (pos == body_q.size()) body_q.push_back(fud_pkg::CH_NUL);
      else body_q.insert(pos, fud_pkg::CH_NUL);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int seg;
    int seg_end;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.in_byte   <= 8'h00;
    in_ch.body_last <= 1'b0;
    bytes_sent   = 0;
    burst_left   = 0;
    gaps_on      = 1'b1;
    hold_req     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: '&' inside a name, plus, escaped percent, full escape,
    // non-hex lead, single hex digit
    push_text("&=+%%%4F%g1%7z");
    send_body();
    // percent as the last byte of a value
    push_text("=%");
    send_body();
    // name dropped by a zero byte, later bytes ignored until the body end
    body_q = '{8'hFF, fud_pkg::CH_NUL, 8'h71, fud_pkg::CH_NUL, 8'h80};
    send_body();
    // zero byte at pair start, also the last byte
    body_q = '{fud_pkg::CH_NUL};
    send_body();
    // body ends inside a name
    push_text("k");
    send_body();
    // escape cut short by '&' on the last byte
    push_text("=%A&");
    send_body();
    // empty name, '=' as the last byte
    push_text("=");
    send_body();
    wait_quiet();

    // random part in segments: gaps on or off, some with a receiver hold-off
    // while the sender keeps pushing, some ending in a full drain
    seg = 0;
    while (bytes_sent < ITEMS_TARGET) begin
      gaps_on = (seg % 3) != 2;
      if (seg % 4 == 1) begin
        gaps_on  = 1'b0;
        hold_req = 1'b1;
      end
      seg_end = bytes_sent + $urandom_range(80, 200);
      if (seg_end > ITEMS_TARGET) seg_end = ITEMS_TARGET;
      while (bytes_sent < seg_end) begin
        build_body();
        send_body();
      end
      if (seg % 3 == 0) wait_quiet();
      seg++;
    end

    wait_quiet();
    if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
      $display("form_urlencoded_decoder regression: pass");
    end else begin
      $display("form_urlencoded_decoder regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/fud_pkg.sv
rtl/fud_ifs.sv
rtl/fud_parser.sv
rtl/form_urlencoded_decoder.sv
tb/tb_form_urlencoded_decoder.sv
